FILE: hw/rtl/ftcs_pkg.sv
// Shared types and constants for the frame time clamp smoother.
package ftcs_pkg;

  localparam int unsigned WINDOW_MAX_DEF       = 64;
  localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

  localparam int unsigned ELAPSED_W    = 32;
  localparam int unsigned STEP_W       = 32;
  localparam int unsigned RATE_W       = 20;
  localparam int unsigned FRAME_W      = 32;
  localparam int unsigned MIN_RATE_W   = 10;
  localparam int unsigned WINDOW_LEN_W = 7;
  localparam int unsigned CFG_DATA_W   = 10;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'd1;

  localparam logic [RATE_W-1:0] RATE_MAX = 20'hFFFFF;

  typedef enum logic [1:0] {
    DIV_LIMIT = 2'd0,
    DIV_MEAN  = 2'd1,
    DIV_RATE  = 2'd2
  } div_sel_e;

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b0000000001,
    ST_CLAMP_GO   = 10'b0000000010,
    ST_CLAMP_WAIT = 10'b0000000100,
    ST_PUSH       = 10'b0000001000,
    ST_SUM        = 10'b0000010000,
    ST_MEAN_GO    = 10'b0000100000,
    ST_MEAN_WAIT  = 10'b0001000000,
    ST_RATE_GO    = 10'b0010000000,
    ST_RATE_WAIT  = 10'b0100000000,
    ST_EMIT       = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_sel_e div_sel;
    logic     clamp;
    logic     push;
    logic     sum_run;
    logic     mean_load;
    logic     rate_load;
    logic     rate_zero;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic clamp_en;
    logic win_en;
    logic need_mean;
    logic sum_done;
    logic step_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/ftcs_div.sv
// Restoring divider, one quotient bit per cycle.
module ftcs_div #(
  parameter int unsigned DVD_W = 39,
  parameter int unsigned DVS_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DVD_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/ftcs_datapath.sv
// Datapath: config registers, sample ring, serial sum, shared divider, output register.
module ftcs_datapath #(
  parameter int unsigned WINDOW_MAX       = ftcs_pkg::WINDOW_MAX_DEF,
  parameter int unsigned TICKS_PER_SECOND = ftcs_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ftcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ftcs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [ftcs_pkg::ELAPSED_W-1:0]    elapsed_ticks_i,
  input  logic                              out_stall_i,
  input  ftcs_pkg::cmd_t                    cmd_i,
  output ftcs_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  output logic [ftcs_pkg::STEP_W-1:0]       step_ticks_o,
  output logic [ftcs_pkg::RATE_W-1:0]       frame_rate_o,
  output logic [ftcs_pkg::FRAME_W-1:0]      frame_number_o
);

  import ftcs_pkg::*;

  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW = STEP_W + CW;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    return (32'(idx) == WINDOW_MAX - 1) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx);
    return (idx == '0) ? AW'(WINDOW_MAX - 1) : idx - 1'b1;
  endfunction

  logic [MIN_RATE_W-1:0]   min_rate_q;
  logic [WINDOW_LEN_W-1:0] win_len_q;
  logic [FRAME_W-1:0]      frame_q;
  logic [CW-1:0]           stored_q;
  logic [AW-1:0]           head_q;
  logic [ELAPSED_W-1:0]    dur_q;
  logic [SW-1:0]           sum_q;
  logic [CW-1:0]           remain_q;
  logic [AW-1:0]           rd_addr_q;
  logic                    rd_pend_q;
  logic [STEP_W-1:0]       rd_data_q;
  logic [STEP_W-1:0]       step_q;
  logic [RATE_W-1:0]       rate_q;
  logic                    out_valid_q;
  logic [STEP_W-1:0]       out_step_q;
  logic [RATE_W-1:0]       out_rate_q;
  logic [FRAME_W-1:0]      out_frame_q;

  logic [STEP_W-1:0]       hist_mem [WINDOW_MAX];

  logic [CW-1:0]           n_win;
  logic [CW:0]             cnt_next;
  logic                    need_mean;
  logic                    rd_en;
  logic [SW-1:0]           div_dvd;
  logic [STEP_W-1:0]       div_dvs;
  logic                    div_done;
  logic [SW-1:0]           div_quo;

  // effective window: saturated to the ring depth
  assign n_win     = (32'(win_len_q) > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(win_len_q);
  assign cnt_next  = {1'b0, stored_q} + 1'b1;
  assign need_mean = (cnt_next > {1'b0, n_win});
  assign rd_en     = cmd_i.sum_run && (remain_q != '0);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_LIMIT: begin
        div_dvd = SW'(TICKS_PER_SECOND);
        div_dvs = STEP_W'(min_rate_q);
      end
      DIV_MEAN: begin
        div_dvd = sum_q;
        div_dvs = STEP_W'(n_win);
      end
      DIV_RATE: begin
        div_dvd = SW'(TICKS_PER_SECOND);
        div_dvs = step_q;
      end
      default: begin
        div_dvd = SW'(TICKS_PER_SECOND);
        div_dvs = step_q;
      end
    endcase
  end

  ftcs_div #(
    .DVD_W (SW),
    .DVS_W (STEP_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rate_q  <= '0;
      win_len_q   <= '0;
      frame_q     <= '0;
      stored_q    <= '0;
      head_q      <= '0;
      remain_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_MIN_RATE)) begin
        min_rate_q <= cfg_data_i[MIN_RATE_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_WINDOW_LEN)) begin
        win_len_q <= cfg_data_i[WINDOW_LEN_W-1:0];
      end
      if (cmd_i.capture) begin
        frame_q <= frame_q + 1'b1;
      end
      if (cmd_i.push && (n_win != '0)) begin
        head_q <= ring_next(head_q);
        if (need_mean) begin
          stored_q <= n_win;
          remain_q <= n_win - 1'b1;
        end else begin
          stored_q <= cnt_next[CW-1:0];
        end
      end else if (rd_en) begin
        remain_q <= remain_q - 1'b1;
      end
      rd_pend_q <= rd_en;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (n_win != '0)) begin
      hist_mem[head_q] <= dur_q;
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr_q];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dur_q <= elapsed_ticks_i;
    end else if (cmd_i.clamp && (SW'(dur_q) > div_quo)) begin
      dur_q <= div_quo[ELAPSED_W-1:0];
    end
    if (cmd_i.push) begin
      // newest sample seeds the sum; older ones are read back from the ring
      sum_q     <= SW'(dur_q);
      rd_addr_q <= ring_prev(head_q);
      step_q    <= dur_q;
    end else begin
      if (rd_en) begin
        rd_addr_q <= ring_prev(rd_addr_q);
      end
      if (cmd_i.sum_run && rd_pend_q) begin
        sum_q <= sum_q + SW'(rd_data_q);
      end
      if (cmd_i.mean_load) begin
        step_q <= div_quo[STEP_W-1:0];
      end
    end
    if (cmd_i.rate_zero) begin
      rate_q <= '0;
    end else if (cmd_i.rate_load) begin
      rate_q <= (div_quo > SW'(RATE_MAX)) ? RATE_MAX : div_quo[RATE_W-1:0];
    end
    if (cmd_i.emit) begin
      out_step_q  <= step_q;
      out_rate_q  <= rate_q;
      out_frame_q <= frame_q;
    end
  end

  assign status_o.clamp_en  = (min_rate_q != '0);
  assign status_o.win_en    = (n_win != '0);
  assign status_o.need_mean = need_mean;
  assign status_o.sum_done  = (remain_q == '0) && !rd_pend_q;
  assign status_o.step_zero = (step_q == '0);
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign step_ticks_o   = out_step_q;
  assign frame_rate_o   = out_rate_q;
  assign frame_number_o = out_frame_q;

endmodule

FILE: hw/rtl/ftcs_ctrl.sv
// Controller state machine sequencing one item through the datapath.
module ftcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ftcs_pkg::status_t status_i,
  output ftcs_pkg::cmd_t    cmd_o,
  output logic              in_stall_o
);

  import ftcs_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_RATE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = status_i.clamp_en ? ST_CLAMP_GO : ST_PUSH;
        end
      end
      ST_CLAMP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_LIMIT;
        state_d = ST_CLAMP_WAIT;
      end
      ST_CLAMP_WAIT: begin
        cmd_o.div_sel = DIV_LIMIT;
        if (status_i.div_done) begin
          cmd_o.clamp = 1'b1;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = (status_i.win_en && status_i.need_mean) ? ST_SUM : ST_RATE_GO;
      end
      ST_SUM: begin
        cmd_o.sum_run = 1'b1;
        if (status_i.sum_done) begin
          state_d = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MEAN;
        state_d = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        cmd_o.div_sel = DIV_MEAN;
        if (status_i.div_done) begin
          cmd_o.mean_load = 1'b1;
          state_d = ST_RATE_GO;
        end
      end
      ST_RATE_GO: begin
        if (status_i.step_zero) begin
          cmd_o.rate_zero = 1'b1;
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_RATE_WAIT;
        end
      end
      ST_RATE_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.rate_load = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/frame_time_clamp_smoother_top.sv
// Top level of the frame time clamp smoother: controller plus datapath.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------------------
//   in       | sink      | in_valid_i / in_stall_o | elapsed_ticks_i
//   out      | source    | out_valid_o/out_stall_i | step_ticks_o, frame_rate_o,
//            |           |                         | frame_number_o
//   cfg      | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One item at a time: accept, optional clamp divide, ring push, then, with averaging, a serial
//   sum over the N-sample window and a mean divide; a rate divide unless the step is zero;
//   hand-off. SW = 32 + clog2(WINDOW_MAX + 1) (39 at default) is the dividend width of the
//   one-bit-per-cycle divider.
// Async active-low reset clears config, ring pointer, fill count, frame counter; not the ring.
// A finished item waits in the output register; a stalled output holds the block only
//   once the next item is ready to leave.
module frame_time_clamp_smoother_top #(
  parameter int unsigned WINDOW_MAX       = ftcs_pkg::WINDOW_MAX_DEF,
  parameter int unsigned TICKS_PER_SECOND = ftcs_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [ftcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ftcs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ftcs_pkg::ELAPSED_W-1:0]  elapsed_ticks_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ftcs_pkg::STEP_W-1:0]     step_ticks_o,
  output logic [ftcs_pkg::RATE_W-1:0]     frame_rate_o,
  output logic [ftcs_pkg::FRAME_W-1:0]    frame_number_o
);

  import ftcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing: accept, optional clamp divide, ring push, optional serial sum
  // and mean divide, rate divide unless the step is zero, hand-off to the output register
  ftcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ftcs_datapath #(
    .WINDOW_MAX       (WINDOW_MAX),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .elapsed_ticks_i (elapsed_ticks_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .step_ticks_o    (step_ticks_o),
    .frame_rate_o    (frame_rate_o),
    .frame_number_o  (frame_number_o)
  );

endmodule

FILE: verif/frame_time_clamp_smoother_top_test.sv
// Self-checking testbench for frame_time_clamp_smoother_top with directed and random frames.
module frame_time_clamp_smoother_top_test;
  import ftcs_pkg::*;

  localparam int unsigned        HIST_DEPTH     = WINDOW_MAX_DEF;
  localparam longint unsigned    TICKS_PER_SEC  = TICKS_PER_SECOND_DEF;
  localparam int unsigned        RANDOM_FRAMES  = 900;
  // Allow for a worst-case item plus slack after draining.
  localparam int unsigned        DRAIN_CYCLES   = 250;
  // Longest quiet stretch: a long sender gap, a worst-case item and a long output stall.
  localparam int unsigned        WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [STEP_W-1:0]  step_ticks;
    logic [RATE_W-1:0]  frame_rate;
    logic [FRAME_W-1:0] frame_number;
  } frame_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ELAPSED_W-1:0]    elapsed_ticks_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [STEP_W-1:0]       step_ticks_o;
  logic [RATE_W-1:0]       frame_rate_o;
  logic [FRAME_W-1:0]      frame_number_o;

  frame_time_clamp_smoother_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .elapsed_ticks_i(elapsed_ticks_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .step_ticks_o   (step_ticks_o),
    .frame_rate_o   (frame_rate_o),
    .frame_number_o (frame_number_o)
  );

  // Shadow of the smoother state, updated as each frame is accepted.
  logic [STEP_W-1:0]       sample_ring [HIST_DEPTH];
  int unsigned             ring_fill;
  int unsigned             ring_head;
  logic [FRAME_W-1:0]      frames_seen;
  logic [MIN_RATE_W-1:0]   min_rate_reg;
  logic [WINDOW_LEN_W-1:0] window_reg;

  frame_result_t           pending_frames [$];
  int unsigned             error_count;
  int unsigned             quiet_cycles;
  bit                      calm_phase;

  always #5 clk_i = ~clk_i;

  // Expected step, rate and frame number for one accepted frame duration.
  task automatic predict_frame(input logic [ELAPSED_W-1:0] ticks);
    logic [STEP_W-1:0] dur;
    longint unsigned   limit;
    longint unsigned   acc;
    longint unsigned   rate;
    int unsigned       n;
    int unsigned       cnt;
    int unsigned       idx;
    int unsigned       k;
    frame_result_t     res;
    dur = ticks;
    if (min_rate_reg != 0) begin
      limit = TICKS_PER_SEC / longint'(min_rate_reg);
      if (longint'(dur) > limit) dur = limit[STEP_W-1:0];
    end
    n = int'(window_reg);
    if (n > HIST_DEPTH) n = HIST_DEPTH;
    res.step_ticks = dur;
    if (n != 0) begin
      sample_ring[ring_head] = dur;
      ring_head = (ring_head + 1) % HIST_DEPTH;
      cnt = ring_fill + 1;
      if (cnt <= n) begin
        ring_fill = cnt;
      end else begin
        // mean of the newest n samples, walking back from the head
        acc = 0;
        idx = ring_head;
        for (k = 0; k < n; k++) begin
          idx = (idx == 0) ? HIST_DEPTH - 1 : idx - 1;
          acc = acc + longint'(sample_ring[idx]);
        end
        ring_fill = n;
        acc = acc / longint'(n);
        res.step_ticks = acc[STEP_W-1:0];
      end
    end
    frames_seen = frames_seen + 1;
    res.frame_number = frames_seen;
    if (res.step_ticks == 0) begin
      res.frame_rate = '0;
    end else begin
      rate = TICKS_PER_SEC / longint'(res.step_ticks);
      if (rate > longint'(RATE_MAX)) rate = longint'(RATE_MAX);
      res.frame_rate = rate[RATE_W-1:0];
    end
    pending_frames = {pending_frames, res};
  endtask

  // Sender gap: mostly none, some short, a few long; none in a calm phase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one frame duration and record its expected result on acceptance.
  task automatic send_frame(input logic [ELAPSED_W-1:0] ticks);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    elapsed_ticks_i <= ticks;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame(ticks);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_MIN_RATE) min_rate_reg = data[MIN_RATE_W-1:0];
    else                     window_reg   = data[WINDOW_LEN_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Both registers in one idle window.
  task automatic configure(input logic [CFG_DATA_W-1:0] rate,
                           input logic [CFG_DATA_W-1:0] win);
    settle();
    write_reg(CFG_MIN_RATE, rate);
    write_reg(CFG_WINDOW_LEN, win);
  endtask

  // No clamp, no window: the duration passes through, zero step gives zero rate.
  task automatic test_passthrough();
    configure(10'd0, 10'd0);
    send_frame(32'd0);
    send_frame(32'd1);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h8000_0000);
    send_frame(32'd1_000_001);
  endtask

  // Clamp limits at the lowest rate, the top of range and a rate of 1000.
  task automatic test_clamp();
    configure(10'd1, 10'd0);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd1_000_000);
    configure(10'd1023, 10'd0);
    send_frame(32'd977);
    send_frame(32'd978);
    configure(10'd1000, 10'd0);
    send_frame(32'd5000);
  endtask

  // Averaging: fill, sum past 32 bits, grow, shrink, saturate, window off.
  task automatic test_window();
    configure(10'd0, 10'd3);
    repeat (4) send_frame(32'hFFFF_FFFF);
    settle();
    write_reg(CFG_WINDOW_LEN, 10'd5);
    send_frame(32'd10);
    send_frame(32'd20);
    settle();
    write_reg(CFG_WINDOW_LEN, 10'd2);
    send_frame(32'd7);
    settle();
    write_reg(CFG_WINDOW_LEN, 10'd100);
    send_frame(32'd3);
    settle();
    write_reg(CFG_WINDOW_LEN, 10'd0);
    send_frame(32'd9);
    settle();
    write_reg(CFG_WINDOW_LEN, 10'd127);
    send_frame(32'd11);
  endtask

  function automatic logic [ELAPSED_W-1:0] pick_ticks();
    int unsigned     r;
    longint unsigned limit;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 40000);
    if (r < 45) begin
      // straddle the clamp limit when one is set
      if (min_rate_reg == 0) return $urandom_range(16000, 17000);
      limit = TICKS_PER_SEC / longint'(min_rate_reg);
      return limit[ELAPSED_W-1:0] + $urandom_range(0, 4) - 2;
    end
    if (r < 62) return $urandom();
    if (r < 72) return $urandom_range(0, 20);
    if (r < 77) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    if (r < 80) return '0;
    return $urandom_range(1000, 2_000_000);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_min_rate();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 40) return 10'd1023;
    if (r < 45) return 10'd1;
    if (r < 55) return CFG_DATA_W'($urandom_range(1001, 1023));
    return CFG_DATA_W'($urandom_range(1, 1000));
  endfunction

  // Mostly small windows to keep the run short, a few at and above the maximum.
  function automatic logic [CFG_DATA_W-1:0] pick_window();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18) return '0;
    if (r < 55) return CFG_DATA_W'($urandom_range(1, 8));
    if (r < 70) return CFG_DATA_W'($urandom_range(9, 63));
    if (r < 78) return 10'd64;
    if (r < 84) return CFG_DATA_W'($urandom_range(65, 127));
    if (r < 90) return CFG_DATA_W'($urandom_range(0, 1023));  // upper data bits ignored
    return CFG_DATA_W'($urandom_range(1, 4));
  endfunction

  // Random phases: new settings (sometimes only one register), then a burst.
  task automatic test_random();
    int unsigned sent;
    int unsigned burst;
    int unsigned r;
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        write_reg(CFG_MIN_RATE, pick_min_rate());
        write_reg(CFG_WINDOW_LEN, pick_window());
      end else if (r < 85) begin
        write_reg(CFG_WINDOW_LEN, pick_window());
      end else begin
        write_reg(CFG_MIN_RATE, pick_min_rate());
      end
      calm_phase = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(10, 60);
      repeat (burst) send_frame(pick_ticks());
      sent += burst;
    end
    calm_phase = 1'b0;
  endtask

  // Output stall pattern: free stretches (some long), stalls mostly short.
  initial begin
    int unsigned free_len;
    int unsigned hold_len;
    out_stall_i = 1'b0;
    forever begin
      free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                             : $urandom_range(1, 12);
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat (free_len) @(negedge clk_i);
      if (!calm_phase) begin
        hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (hold_len - 1) @(negedge clk_i);
      end
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    frame_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result: step_ticks %0d frame_number %0d",
               step_ticks_o, frame_number_o);
        error_count++;
      end else begin
        want = pending_frames.pop_front();
        if (step_ticks_o !== want.step_ticks) begin
          $error("step_ticks: expected %0d, got %0d", want.step_ticks, step_ticks_o);
          error_count++;
        end
        if (frame_rate_o !== want.frame_rate) begin
          $error("frame_rate: expected %0d, got %0d", want.frame_rate, frame_rate_o);
          error_count++;
        end
        if (frame_number_o !== want.frame_number) begin
          $error("frame_number: expected %0d, got %0d",
                 want.frame_number, frame_number_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without an item moving on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_MIN_RATE;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    elapsed_ticks_i = '0;
    ring_fill       = 0;
    ring_head       = 0;
    frames_seen     = '0;
    min_rate_reg    = '0;
    window_reg      = '0;
    error_count     = 0;
    quiet_cycles    = 0;
    calm_phase      = 1'b0;
    foreach (sample_ring[i]) sample_ring[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_passthrough();
    test_clamp();
    test_window();
    test_random();

    // Drain, then leave room for any stray result.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ftcs_pkg.sv
hw/rtl/ftcs_div.sv
hw/rtl/ftcs_datapath.sv
hw/rtl/ftcs_ctrl.sv
hw/rtl/frame_time_clamp_smoother_top.sv
verif/frame_time_clamp_smoother_top_test.sv
